@@ hw/rtl/stepper_half_step_move_sequencer_unit_assert.svh @@
`ifndef STEPPER_HALF_STEP_MOVE_SEQUENCER_UNIT_ASSERT_SVH
`define STEPPER_HALF_STEP_MOVE_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define SHSMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define SHSMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ hw/rtl/shsms_pkg.sv @@
package shsms_pkg;

   localparam int AngleW = 16;
   localparam int DivW   = 16;
   localparam int TurnW  = 8;
   localparam int PartW  = 10;
   localparam int CycW   = 17;
   localparam int PerW   = 8;
   localparam int PhW    = 3;
   localparam int CoilW  = 4;

   localparam logic [DivW-1:0]  DEG_PER_TURN   = 16'd360;
   localparam logic [DivW-1:0]  STEP_NUMERATOR = 16'd36000;
   localparam logic [DivW-1:0]  PART_NUMERATOR = 16'd51200;
   localparam logic [CycW-1:0]  CYCLES_MAX     = 17'd131071;
   localparam logic [PerW-1:0]  PERIOD_RESET   = 8'd2;
   localparam logic [PhW-1:0]   PHASE_LAST     = 3'd7;

   localparam logic [0:0] CMD_START = 1'b0;
   localparam logic [0:0] CMD_TICK  = 1'b1;

   typedef logic [CoilW-1:0] coil_table_type [8];

   localparam coil_table_type TAB_FWD = '{4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};
   localparam coil_table_type TAB_REV = '{4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8};

   typedef struct packed {
      logic              cmd;
      logic [AngleW-1:0] angle_degrees;
      logic              clockwise;
   } req_payload_type;

   typedef struct packed {
      logic [CoilW-1:0] coil_pattern;
      logic             busy_res;
      logic             done_res;
      logic             accepted;
   } rsp_payload_type;

   typedef logic [PerW-1:0] csr_payload_type;

   typedef struct packed {
      logic            start;
      logic [DivW-1:0] dividend;
      logic [DivW-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic            done;
      logic [DivW-1:0] quotient;
      logic [DivW-1:0] remainder;
   } div_stat_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DIV_TURN = 7'b0000010,
      ST_DIV_STEP = 7'b0000100,
      ST_DIV_PART = 7'b0001000,
      ST_MUL      = 7'b0010000,
      ST_SUM      = 7'b0100000,
      ST_RESP     = 7'b1000000
   } state_type;

   function automatic logic [CoilW-1:0] coil_of(input logic dir, input logic [PhW-1:0] ph);
      coil_of = dir ? TAB_FWD[ph] : TAB_REV[ph];
   endfunction

endpackage

@@ hw/rtl/shsms_stream_if.sv @@
interface shsms_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/shsms_div.sv @@
module shsms_div (
   input  logic                    clock,
   input  logic                    reset,
   input  shsms_pkg::div_cmd_type  div_cmd,
   output shsms_pkg::div_stat_type div_stat
);
   import shsms_pkg::*;

   localparam int CntW = $clog2(DivW);

   logic [DivW:0]      rem_ff, rem_in;
   logic [DivW-1:0]    quo_ff, quo_in;
   logic [DivW-1:0]    dsr_ff, dsr_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [DivW:0]      shifted;
   logic [DivW+1:0]    diff;

   always_comb begin
      shifted = {rem_ff[DivW-1:0], quo_ff[DivW-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_cmd.start) begin
         rem_in = '0;
         quo_in = div_cmd.dividend;
         dsr_in = div_cmd.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // one restoring step per cycle
         if (!diff[DivW+1]) begin
            rem_in = diff[DivW:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(DivW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_stat.done      = done_ff;
   assign div_stat.quotient  = quo_ff;
   assign div_stat.remainder = rem_ff[DivW-1:0];

endmodule

@@ hw/rtl/stepper_half_step_move_sequencer_unit.sv @@
// tick transaction or start while busy: response valid in the cycle after acceptance
// start transaction: three passes through the shared 16-bit radix-2 divider, only one when the angle
//   is a multiple of 360, then the multiply and sum states, before the response
// one transaction in flight at a time; req_chan.ready is low until the response is taken
// synchronous active-high reset: motor idle, coils off, step period 2, no clearing pass
`include "stepper_half_step_move_sequencer_unit_assert.svh"

module stepper_half_step_move_sequencer_unit #(
   parameter int CYCLES_PER_TURN = 512
) (
   input logic            clock,
   input logic            reset,
   shsms_stream_if.sink   req_chan,
   shsms_stream_if.source rsp_chan,
   shsms_stream_if.sink   csr_chan
);
   import shsms_pkg::*;

   localparam int CptW = $clog2(CYCLES_PER_TURN + 1);
   localparam int ProdW = TurnW + CptW;
   localparam int SumW = ((ProdW > CycW) ? ProdW : CycW) + 1;

   state_type          state_ff, state_in;
   logic [PerW-1:0]    period_ff;
   logic [CycW-1:0]    cycles_left_ff, cycles_left_in;
   logic [PhW-1:0]     phase_ff, phase_in;
   logic               dir_ff, dir_in;
   logic [PerW-1:0]    hold_ff, hold_in;
   logic [CoilW-1:0]   coil_ff, coil_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               acc_ff, acc_in;
   logic               cw_pend_ff, cw_pend_in;
   logic [TurnW-1:0]   turns_ff, turns_in;
   logic [PartW-1:0]   part_ff, part_in;
   logic [ProdW-1:0]   prod_ff, prod_in;

   logic               req_take;
   logic [PerW-1:0]    per;
   logic [PerW-1:0]    hold_inc;
   logic [SumW-1:0]    total;
   logic [CycW-1:0]    total_sat;
   div_cmd_type        div_cmd;
   div_stat_type       div_stat;

   shsms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_cmd  (div_cmd),
      .div_stat (div_stat)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign per       = (period_ff == '0) ? PerW'(1) : period_ff;
   assign hold_inc  = hold_ff + 1'b1;
   assign total     = SumW'(prod_ff) + SumW'(part_ff);
   assign total_sat = (total > SumW'(CYCLES_MAX)) ? CYCLES_MAX : total[CycW-1:0];

   always_comb begin
      state_in       = state_ff;
      cycles_left_in = cycles_left_ff;
      phase_in       = phase_ff;
      dir_in         = dir_ff;
      hold_in        = hold_ff;
      coil_in        = coil_ff;
      busy_in        = busy_ff;
      done_in        = done_ff;
      acc_in         = acc_ff;
      cw_pend_in     = cw_pend_ff;
      turns_in       = turns_ff;
      part_in        = part_ff;
      prod_in        = prod_ff;
      div_cmd        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               done_in  = 1'b0;
               acc_in   = 1'b0;
               state_in = ST_RESP;
               if (req_chan.payload.cmd == CMD_START) begin
                  if (!busy_ff) begin
                     cw_pend_in       = req_chan.payload.clockwise;
                     div_cmd.start    = 1'b1;
                     div_cmd.dividend = req_chan.payload.angle_degrees;
                     div_cmd.divisor  = DEG_PER_TURN;
                     state_in         = ST_DIV_TURN;
                  end
               end else if (busy_ff) begin
                  if (hold_inc >= per) begin
                     hold_in = '0;
                     if (phase_ff == PHASE_LAST) begin
                        phase_in       = '0;
                        cycles_left_in = cycles_left_ff - 1'b1;
                        if (cycles_left_ff == CycW'(1)) begin
                           busy_in = 1'b0;
                           done_in = 1'b1;
                        end else begin
                           coil_in = coil_of(dir_ff, '0);
                        end
                     end else begin
                        phase_in = phase_ff + 1'b1;
                        coil_in  = coil_of(dir_ff, phase_ff + 1'b1);
                     end
                  end else begin
                     hold_in = hold_inc;
                  end
               end
            end
         end
         ST_DIV_TURN: begin
            if (div_stat.done) begin
               turns_in = div_stat.quotient[TurnW-1:0];
               if (div_stat.remainder == '0) begin
                  part_in  = '0;
                  state_in = ST_MUL;
               end else begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = STEP_NUMERATOR;
                  div_cmd.divisor  = div_stat.remainder;
                  state_in         = ST_DIV_STEP;
               end
            end
         end
         ST_DIV_STEP: begin
            if (div_stat.done) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = PART_NUMERATOR;
               div_cmd.divisor  = div_stat.quotient;
               state_in         = ST_DIV_PART;
            end
         end
         ST_DIV_PART: begin
            if (div_stat.done) begin
               part_in  = div_stat.quotient[PartW-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = ProdW'(turns_ff) * ProdW'(CYCLES_PER_TURN);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = 1'b1;
            state_in = ST_RESP;
            if (total_sat == '0) begin
               done_in = 1'b1;
            end else begin
               done_in        = 1'b0;
               cycles_left_in = total_sat;
               dir_in         = cw_pend_ff;
               phase_in       = '0;
               hold_in        = '0;
               coil_in        = coil_of(cw_pend_ff, '0);
               busy_in        = 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         period_ff      <= PERIOD_RESET;
         cycles_left_ff <= '0;
         phase_ff       <= '0;
         dir_ff         <= 1'b0;
         hold_ff        <= '0;
         coil_ff        <= '0;
         busy_ff        <= 1'b0;
         done_ff        <= 1'b0;
         acc_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cycles_left_ff <= cycles_left_in;
         phase_ff       <= phase_in;
         dir_ff         <= dir_in;
         hold_ff        <= hold_in;
         coil_ff        <= coil_in;
         busy_ff        <= busy_in;
         done_ff        <= done_in;
         acc_ff         <= acc_in;
         if (csr_chan.valid) begin
            period_ff <= csr_chan.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      cw_pend_ff <= cw_pend_in;
      turns_ff   <= turns_in;
      part_ff    <= part_in;
      prod_ff    <= prod_in;
   end

   assign rsp_chan.valid                = (state_ff == ST_RESP);
   assign rsp_chan.payload.coil_pattern = coil_ff;
   assign rsp_chan.payload.busy_res     = busy_ff;
   assign rsp_chan.payload.done_res     = done_ff;
   assign rsp_chan.payload.accepted     = acc_ff;

   `SHSMS_ASSERT_NOW(a_ready_no_rsp, clock, reset, req_chan.ready, !rsp_chan.valid)
   `SHSMS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_chan.ready)
   `SHSMS_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_chan.valid && done_ff, !busy_ff)
   `SHSMS_ASSERT_NOW(a_busy_has_cycles, clock, reset, busy_ff, cycles_left_ff != '0)

endmodule
